// ===== rtl/dhfm_pkg.sv =====
// shared constants and types for the debounced hysteresis fault monitor
package dhfm_pkg;

  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_W    = 3;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;
  localparam int CH_W         = 3;
  localparam int NUM_CHANNELS = 8;
  localparam int VAL_W        = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CNT_W        = 16;
  localparam int WORD_W       = NUM_CHANNELS + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [VAL_W-1:0] SAMPLE_MASK = VAL_W'((32'd1 << SAMPLE_WIDTH) - 32'd1);

  typedef struct packed {
    logic [VAL_W-1:0] reset_limit;
    logic [VAL_W-1:0] trip_limit;
    logic [VAL_W-1:0] clear_thresh;
    logic [VAL_W-1:0] trip_thresh;
  } setting_t;

  typedef struct packed {
    logic [CNT_W-1:0] trip_count;
    logic [CNT_W-1:0] release_cnt;
  } cnt_t;

endpackage

// ===== rtl/dhfm_cfg.sv =====
// apb register file holding the per-channel settings memory
module dhfm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dhfm_pkg::ADDR_W-1:0]       paddr,
  input  logic [dhfm_pkg::DATA_W-1:0]       pwdata,
  output logic [dhfm_pkg::DATA_W-1:0]       prdata,
  input  logic                              rd_en,
  input  logic [dhfm_pkg::REG_IDX_W-1:0]    rd_addr,
  output dhfm_pkg::setting_t                rd_setting
);
  import dhfm_pkg::*;

  setting_t                  mem [NUM_REGS];
  logic [NUM_REGS-1:0]       valid;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[ADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[reg_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[reg_idx] <= setting_t'(pwdata);
    end
  end

  // host read data is fetched in the setup cycle
  always_ff @(posedge clk) begin
    if (psel && !penable) begin
      prdata <= valid[reg_idx] ? DATA_W'(mem[reg_idx]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_setting <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ===== rtl/dhfm_cnt_mem.sv =====
// per-channel trip and release counter memory
module dhfm_cnt_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [dhfm_pkg::CH_W-1:0]    rd_addr,
  output dhfm_pkg::cnt_t               rd_data,
  input  logic                         wr_en,
  input  logic [dhfm_pkg::CH_W-1:0]    wr_addr,
  input  dhfm_pkg::cnt_t               wr_data
);
  import dhfm_pkg::*;

  cnt_t                    mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

// ===== rtl/debounced_hysteresis_fault_monitor.sv =====
// Debounced window-comparator fault monitor. Each sample transfer names a channel and a
// value; one fault_word transfer follows per sample, registered after the s1 stage, and a
// new sample is taken every cycle unless the result side stalls. The sustained rate of
// one sample per cycle is set by the counter memory's single read-modify-write loop: the
// counters are read at acceptance, updated in s1 and written back as it advances, with
// the last write forwarded to a following sample of the same channel. Channel settings
// are 64-bit registers at byte address 8*k, written and read over the APB port.
module debounced_hysteresis_fault_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhfm_pkg::ADDR_W-1:0]   paddr,
  input  logic [dhfm_pkg::DATA_W-1:0]   pwdata,
  output logic [dhfm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic [dhfm_pkg::CH_W-1:0]     channel,
  input  logic [dhfm_pkg::VAL_W-1:0]    sample_value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [dhfm_pkg::WORD_W-1:0]   fault_word
);
  import dhfm_pkg::*;

  logic                    in_fire;
  logic                    s1_fire;
  logic                    s1_valid;
  logic [CH_W-1:0]         s1_channel;
  logic [VAL_W-1:0]        s1_value;
  setting_t                s1_setting;
  cnt_t                    rd_cnt;
  cnt_t                    cur_cnt;
  cnt_t                    new_cnt;
  logic                    fwd_valid;
  logic [CH_W-1:0]         fwd_channel;
  cnt_t                    fwd_cnt;
  logic [NUM_CHANNELS-1:0] channel_faults;
  logic [NUM_CHANNELS-1:0] faults_next;
  logic [VAL_W-1:0]        trip_thresh;
  logic [VAL_W-1:0]        clear_thresh;
  logic                    ch_ok;
  logic                    tripping;
  logic                    releasing;
  logic [CNT_W-1:0]        trip_inc;
  logic [CNT_W-1:0]        release_inc;

  assign pready       = 1'b1;
  assign in_fire      = sample_valid && sample_ready;
  assign s1_fire      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || s1_fire;

  dhfm_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .rd_en      (in_fire),
    .rd_addr    (channel),
    .rd_setting (s1_setting)
  );

  dhfm_cnt_mem u_cnt_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (channel),
    .rd_data (rd_cnt),
    .wr_en   (s1_fire && ch_ok),
    .wr_addr (s1_channel),
    .wr_data (new_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_channel <= channel;
      s1_value   <= sample_value & SAMPLE_MASK;
    end
  end

  // latest counter write, forwarded past the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_fire && ch_ok) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && ch_ok) begin
      fwd_channel <= s1_channel;
      fwd_cnt     <= new_cnt;
    end
  end

  always_comb begin
    ch_ok        = ({1'b0, s1_channel} < (CH_W+1)'(NUM_CHANNELS));
    cur_cnt      = (fwd_valid && fwd_channel == s1_channel) ? fwd_cnt : rd_cnt;
    trip_thresh  = s1_setting.trip_thresh & SAMPLE_MASK;
    clear_thresh = s1_setting.clear_thresh & SAMPLE_MASK;
    if (trip_thresh > clear_thresh) begin
      tripping  = s1_value >= trip_thresh;
      releasing = s1_value <= clear_thresh;
    end else begin
      tripping  = s1_value <= trip_thresh;
      releasing = s1_value >= clear_thresh;
    end
    trip_inc    = (cur_cnt.trip_count == COUNT_MAX) ? cur_cnt.trip_count
                                                    : cur_cnt.trip_count + CNT_W'(1);
    release_inc = (cur_cnt.release_cnt == COUNT_MAX) ? cur_cnt.release_cnt
                                                     : cur_cnt.release_cnt + CNT_W'(1);
    faults_next = channel_faults;
    new_cnt     = '0;
    if (tripping) begin
      new_cnt.trip_count = trip_inc;
      if (ch_ok && trip_inc > s1_setting.trip_limit) begin
        faults_next[s1_channel] = 1'b1;
      end
    end else if (releasing) begin
      new_cnt.release_cnt = release_inc;
      if (ch_ok && release_inc > s1_setting.reset_limit) begin
        faults_next[s1_channel] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_faults <= '0;
    end else if (s1_fire) begin
      channel_faults <= faults_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fault_word <= {faults_next, |faults_next};
    end
  end

endmodule
